>>> sv/linear_probe_hash_map_assert.svh
// assertion macros for the hash map block
`ifndef LINEAR_PROBE_HASH_MAP_ASSERT_SVH
`define LINEAR_PROBE_HASH_MAP_ASSERT_SVH

// plain property, sampled on clk_i, off during reset
`define LPHM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// same-cycle implication
`define LPHM_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

>>> sv/lphm_pkg.sv
// ----------------------------------------------------------------------------
// lphm_pkg
// types and constants for the linear probing hash map
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lphm_pkg;

  localparam int unsigned SLOTS_DEF = 256;

  typedef enum logic [1:0] {
    MODE_GET     = 2'd0,
    MODE_SET     = 2'd1,
    MODE_SET_GET = 2'd2,
    MODE_POP     = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    STAT_PRESENT = 2'd0,
    STAT_ABSENT  = 2'd1,
    STAT_FULL    = 2'd2,
    STAT_RSVD    = 2'd3
  } status_e;

  localparam logic [1:0] TAG_EMPTY = 2'd0;
  localparam logic [1:0] TAG_LIVE  = 2'd1;
  localparam logic [1:0] TAG_TOMB  = 2'd2;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HASH,
    ST_READ,
    ST_CHECK,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [1:0]  mode;
    logic [63:0] key;
    logic [63:0] value;
  } in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [63:0] data_out;
    logic        inserted;
  } out_t;

endpackage

`default_nettype wire

>>> sv/linear_probe_hash_map.sv
// requests: one is taken only in the idle state, so a new request waits until the
//   last one has finished its probe; key hashing runs on one shared 32 x 32 multiplier,
//   then each probed slot is read through the tag, key and value memories and checked,
//   then the result word is registered and held while the output is stalled
// reset: a clearing pass over every slot marks each tag empty; no request is
//   taken until it ends
// ----------------------------------------------------------------------------
// linear_probe_hash_map
// open addressing key/value map with linear probing and tombstones
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "linear_probe_hash_map_assert.svh"

module linear_probe_hash_map
  import lphm_pkg::*;
#(
  parameter int unsigned SLOTS = SLOTS_DEF
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_stall_o,
  input  wire in_t  in_data_i,
  output logic      out_valid_o,
  input  wire logic out_stall_i,
  output out_t      out_data_o
);

  localparam int unsigned IDX_W    = $clog2(SLOTS);
  localparam int unsigned CNT_W    = $clog2(SLOTS + 1);
  localparam int unsigned MAX_LOAD = (SLOTS / 4) * 3;
  localparam logic [IDX_W-1:0] LAST    = IDX_W'(SLOTS - 1);
  localparam logic [CNT_W:0]   MAX_X   = (CNT_W + 1)'(MAX_LOAD);
  localparam logic [63:0]      MIX_C1  = 64'hff51afd7ed558ccd;
  localparam logic [63:0]      MIX_C2  = 64'hc4ceb9fe1a85ec53;

  // memories
  logic [1:0]  tag_mem [SLOTS];
  logic [63:0] key_mem [SLOTS];
  logic [63:0] val_mem [SLOTS];

  logic [1:0]  tag_rd_q;
  logic [63:0] key_rd_q, val_rd_q;

  logic             tag_we, kv_we;
  logic [IDX_W-1:0] tag_waddr;
  logic [1:0]       tag_wdata;

  state_e state_q, state_d;
  in_t    req_q, req_d;
  logic [IDX_W-1:0] idx_q, idx_d, step_q, step_d, tomb_q, tomb_d;
  logic [IDX_W-1:0] where_q, where_d, clr_q, clr_d;
  logic tomb_vld_q, tomb_vld_d, hit_q, hit_d, free_q, free_d, grow_q, grow_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic out_valid_q, out_valid_d;
  out_t out_q, out_d;

  // key mixer state: two 64-bit multiplies, each three passes of the unit
  logic [63:0] hash_q, hash_d, acc_q, acc_d;
  logic        hround_q, hround_d;
  logic [1:0]  hphase_q, hphase_d;
  logic [63:0] c_sel;
  logic [31:0] mul_a, mul_b, acc_hi;
  logic [63:0] mul_p, acc_sum, mixed;

  // shared 32 x 32 unit: low x low, then the two cross terms into the top half
  assign c_sel   = hround_q ? MIX_C2 : MIX_C1;
  assign mul_a   = (hphase_q == 2'd1) ? hash_q[63:32] : hash_q[31:0];
  assign mul_b   = (hphase_q == 2'd2) ? c_sel[63:32] : c_sel[31:0];
  assign mul_p   = {32'd0, mul_a} * {32'd0, mul_b};
  assign acc_hi  = acc_q[63:32] + mul_p[31:0];
  assign acc_sum = {acc_hi, acc_q[31:0]};
  assign mixed   = acc_sum ^ (acc_sum >> 33);

  always_ff @(posedge clk_i) begin
    tag_rd_q <= tag_mem[idx_q];
    key_rd_q <= key_mem[idx_q];
    val_rd_q <= val_mem[idx_q];
    if (tag_we) begin
      tag_mem[tag_waddr] <= tag_wdata;
    end
    if (kv_we) begin
      key_mem[where_q] <= req_q.key;
      val_mem[where_q] <= req_q.value;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      idx_q       <= '0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
      idx_q       <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q      <= req_d;
    step_q     <= step_d;
    tomb_q     <= tomb_d;
    tomb_vld_q <= tomb_vld_d;
    where_q    <= where_d;
    hit_q      <= hit_d;
    free_q     <= free_d;
    grow_q     <= grow_d;
    out_q      <= out_d;
    hash_q     <= hash_d;
    acc_q      <= acc_d;
    hround_q   <= hround_d;
    hphase_q   <= hphase_d;
  end

  always_comb begin
    logic is_set;
    logic tv;
    state_d     = state_q;
    req_d       = req_q;
    idx_d       = idx_q;
    step_d      = step_q;
    tomb_d      = tomb_q;
    tomb_vld_d  = tomb_vld_q;
    where_d     = where_q;
    hit_d       = hit_q;
    free_d      = free_q;
    grow_d      = grow_q;
    clr_d       = clr_q;
    cnt_d       = cnt_q;
    out_d       = out_q;
    hash_d      = hash_q;
    acc_d       = acc_q;
    hround_d    = hround_q;
    hphase_d    = hphase_q;
    out_valid_d = out_valid_q && out_stall_i;
    tag_we      = 1'b0;
    tag_waddr   = where_q;
    tag_wdata   = TAG_LIVE;
    kv_we       = 1'b0;
    in_stall_o  = 1'b1;
    is_set      = (req_q.mode == MODE_SET) || (req_q.mode == MODE_SET_GET);
    tv          = tomb_vld_q;
    unique case (state_q)
      ST_CLEAR: begin
        tag_we    = 1'b1;
        tag_waddr = clr_q;
        tag_wdata = TAG_EMPTY;
        clr_d     = clr_q + 1'b1;
        if (clr_q == LAST) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          req_d    = in_data_i;
          hash_d   = in_data_i.key ^ (in_data_i.key >> 33);
          hround_d = 1'b0;
          hphase_d = 2'd0;
          state_d  = ST_HASH;
        end
      end
      ST_HASH: begin
        unique case (hphase_q)
          2'd0: begin
            acc_d    = mul_p;
            hphase_d = 2'd1;
          end
          2'd1: begin
            acc_d    = acc_sum;
            hphase_d = 2'd2;
          end
          default: begin
            hash_d   = mixed;
            hphase_d = 2'd0;
            hround_d = 1'b1;
            if (hround_q) begin
              // slot count is a power of two, so the low bits are the remainder
              idx_d      = mixed[IDX_W-1:0];
              step_d     = '0;
              tomb_vld_d = 1'b0;
              state_d    = ST_READ;
            end
          end
        endcase
      end
      ST_READ: begin
        state_d = ST_CHECK;
      end
      ST_CHECK: begin
        priority if (tag_rd_q == TAG_EMPTY) begin
          hit_d   = 1'b0;
          free_d  = 1'b1;
          grow_d  = !tomb_vld_q;
          where_d = tomb_vld_q ? tomb_q : idx_q;
          state_d = ST_DONE;
        end else if (tag_rd_q == TAG_LIVE && key_rd_q == req_q.key) begin
          hit_d   = 1'b1;
          where_d = idx_q;
          state_d = ST_DONE;
        end else begin
          // tombstone or unused tag code: remember the first one
          if (tag_rd_q != TAG_LIVE && !tomb_vld_q) begin
            tomb_d     = idx_q;
            tomb_vld_d = 1'b1;
            tv         = 1'b1;
          end
          if (step_q == LAST) begin
            hit_d   = 1'b0;
            free_d  = tv;
            grow_d  = 1'b0;
            where_d = tomb_vld_q ? tomb_q : idx_q;
            state_d = ST_DONE;
          end else begin
            idx_d   = (idx_q == LAST) ? '0 : idx_q + 1'b1;
            step_d  = step_q + 1'b1;
            state_d = ST_READ;
          end
        end
      end
      ST_DONE: begin
        if (!(out_valid_q && out_stall_i)) begin
          out_valid_d      = 1'b1;
          out_d.status     = STAT_ABSENT;
          out_d.data_out   = '0;
          out_d.inserted   = 1'b0;
          state_d          = ST_IDLE;
          if (hit_q) begin
            out_d.status   = STAT_PRESENT;
            out_d.data_out = val_rd_q;
            if (req_q.mode == MODE_SET) begin
              kv_we          = 1'b1;
              out_d.data_out = req_q.value;
            end
            if (req_q.mode == MODE_POP) begin
              tag_we    = 1'b1;
              tag_wdata = TAG_TOMB;
            end
          end else if (is_set) begin
            if (({1'b0, cnt_q} + 1'b1 > MAX_X) || !free_q) begin
              out_d.status = STAT_FULL;
            end else begin
              tag_we         = 1'b1;
              tag_wdata      = TAG_LIVE;
              kv_we          = 1'b1;
              out_d.data_out = req_q.value;
              out_d.inserted = 1'b1;
              if (grow_q) begin
                cnt_d = cnt_q + 1'b1;
              end
            end
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `LPHM_ASSERT(a_load_limit, ({1'b0, cnt_q} <= MAX_X), "occupancy above load limit")
  `LPHM_ASSERT_IMPL(a_rise_from_done, $rose(out_valid_o), $past(state_q) == ST_DONE,
    "result word without a finished probe")
  `LPHM_ASSERT_IMPL(a_ins_absent, out_valid_o && out_data_o.inserted,
    out_data_o.status == STAT_ABSENT, "insert flagged on a non-absent result")
  `LPHM_ASSERT_IMPL(a_cnt_step, cnt_q != $past(cnt_q), cnt_q == $past(cnt_q) + 1'b1,
    "occupancy moved by other than one")
  `LPHM_ASSERT(a_slots_pow2, ((SLOTS & (SLOTS - 1)) == 0), "slot count not a power of two")

endmodule

`default_nettype wire

>>> verif/lphm_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lphm_checker
// watches both channels of the hash map, keeps a shadow table that mirrors
// the probe, insert and tombstone rules, and compares every result word
// ----------------------------------------------------------------------------
module lphm_checker
  import lphm_pkg::*;
#(
  parameter int unsigned SLOTS = SLOTS_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  logic in_stall_i,
  input  in_t  in_data_i,
  input  logic out_valid_i,
  input  logic out_stall_i,
  input  out_t out_data_i,
  output int   fail_count_o,
  output int   pending_o
);

  localparam int unsigned LOAD_LIMIT = (SLOTS / 4) * 3;

  logic [1:0]  shadow_tag   [SLOTS];
  logic [63:0] shadow_key   [SLOTS];
  logic [63:0] shadow_value [SLOTS];
  int unsigned shadow_fill;
  out_t        expected_results[$];

  // 64-bit mixer, reduced to a slot index
  function automatic int unsigned home_index(logic [63:0] k);
    logic [63:0] m;
    m = k;
    m = m ^ (m >> 33);
    m = m * 64'hff51afd7ed558ccd;
    m = m ^ (m >> 33);
    m = m * 64'hc4ceb9fe1a85ec53;
    m = m ^ (m >> 33);
    return int'(m % SLOTS);
  endfunction

  function automatic out_t apply_request(in_t w);
    int unsigned idx;
    int unsigned tomb;
    int unsigned slot;
    bit          hit;
    bit          stop;
    out_t        r;
    idx  = home_index(w.key);
    tomb = SLOTS;
    slot = SLOTS;
    hit  = 1'b0;
    stop = 1'b0;
    r    = '{status: STAT_ABSENT, data_out: '0, inserted: 1'b0};
    for (int n = 0; n < SLOTS && !stop; n++) begin
      if (shadow_tag[idx] == TAG_EMPTY) begin
        slot = (tomb != SLOTS) ? tomb : idx;
        stop = 1'b1;
      end else if (shadow_tag[idx] == TAG_LIVE) begin
        if (shadow_key[idx] == w.key) begin
          slot = idx;
          hit  = 1'b1;
          stop = 1'b1;
        end
      end else if (tomb == SLOTS) begin
        tomb = idx;
      end
      if (!stop) idx = (idx + 1 == SLOTS) ? 0 : idx + 1;
    end
    if (!stop) slot = tomb;
    if (hit) begin
      r.status = STAT_PRESENT;
      if (w.mode == MODE_SET) shadow_value[slot] = w.value;
      r.data_out = shadow_value[slot];
      if (w.mode == MODE_POP) shadow_tag[slot] = TAG_TOMB;
    end else if (w.mode == MODE_SET || w.mode == MODE_SET_GET) begin
      if (shadow_fill + 1 > LOAD_LIMIT || slot >= SLOTS) begin
        r.status = STAT_FULL;
      end else begin
        if (shadow_tag[slot] == TAG_EMPTY) shadow_fill++;
        shadow_tag[slot]   = TAG_LIVE;
        shadow_key[slot]   = w.key;
        shadow_value[slot] = w.value;
        r.data_out         = w.value;
        r.inserted         = 1'b1;
      end
    end
    return r;
  endfunction

  initial begin
    fail_count_o = 0;
    shadow_fill  = 0;
    for (int i = 0; i < SLOTS; i++) begin
      shadow_tag[i]   = TAG_EMPTY;
      shadow_key[i]   = '0;
      shadow_value[i] = '0;
    end
  end

  assign pending_o = expected_results.size();

  always @(posedge clk_i) begin
    out_t want;
    if (rst_ni) begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_results.size() == 0) begin
          $display("%0t: result word with nothing expected: got %h", $time, out_data_i);
          fail_count_o++;
        end else begin
          want = expected_results.pop_front();
          if (out_data_i.status !== want.status) begin
            $display("%0t: status expected %0d got %0d", $time, want.status,
                     out_data_i.status);
            fail_count_o++;
          end
          if (out_data_i.data_out !== want.data_out) begin
            $display("%0t: data_out expected %h got %h", $time, want.data_out,
                     out_data_i.data_out);
            fail_count_o++;
          end
          if (out_data_i.inserted !== want.inserted) begin
            $display("%0t: inserted expected %0b got %0b", $time, want.inserted,
                     out_data_i.inserted);
            fail_count_o++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) expected_results.push_back(apply_request(in_data_i));
    end
  end

endmodule

>>> verif/tb_linear_probe_hash_map.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_linear_probe_hash_map
// drives get, set, set-or-get and pop requests over a reused key pool that keeps
// growing with new keys; a checker beside the block grades results
// ----------------------------------------------------------------------------
module tb_linear_probe_hash_map;
  import lphm_pkg::*;

  localparam int unsigned SLOTS       = SLOTS_DEF;
  localparam int          CYCLE_LIMIT = 4000000;
  localparam logic [63:0] ALL_ONES    = '1;

  logic clk_i       = 1'b0;
  logic rst_ni      = 1'b0;
  logic in_valid_i  = 1'b0;
  in_t  in_data_i   = '0;
  logic out_stall_i = 1'b0;
  logic in_stall_o;
  logic out_valid_o;
  out_t out_data_o;

  int          fail_count;
  int          pending;
  int          cycles     = 0;
  int unsigned snd_idle   = 0;
  int unsigned rcv_idle   = 0;
  logic [63:0] key_pool[$];

  always #10 clk_i = ~clk_i;

  linear_probe_hash_map #(.SLOTS(SLOTS)) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  lphm_checker #(.SLOTS(SLOTS)) u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_i  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_i (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_i  (out_data_o),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < rcv_idle);
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_linear_probe_hash_map: FAIL");
      $finish;
    end
  end

  task automatic send_request(mode_e m, logic [63:0] k, logic [63:0] v);
    while ($urandom_range(99) < snd_idle) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= '{mode: m, key: k, value: v};
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  function automatic logic [63:0] rand_word();
    case ($urandom_range(9))
      0:       return '0;
      1:       return ALL_ONES;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // new keys push the fill count toward the load limit, pool keys revisit earlier keys
  task automatic random_phase(int count, int unsigned new_pct);
    logic [63:0] k;
    for (int i = 0; i < count; i++) begin
      if (key_pool.size() == 0 || $urandom_range(99) < new_pct) begin
        k = {$urandom, $urandom};
        key_pool.push_back(k);
      end else begin
        k = key_pool[$urandom_range(key_pool.size() - 1)];
      end
      send_request(mode_e'($urandom_range(3)), k, rand_word());
    end
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: absent, insert, overwrite, present set-or-get, pop, tombstone reuse
    send_request(MODE_GET,     '0,       '0);
    send_request(MODE_POP,     '0,       '0);
    send_request(MODE_SET,     '0,       ALL_ONES);
    send_request(MODE_GET,     '0,       '0);
    send_request(MODE_SET,     '0,       '0);
    send_request(MODE_SET_GET, '0,       ALL_ONES);
    send_request(MODE_SET_GET, ALL_ONES, ALL_ONES);
    send_request(MODE_GET,     ALL_ONES, '0);
    send_request(MODE_POP,     ALL_ONES, '0);
    send_request(MODE_POP,     ALL_ONES, '0);
    send_request(MODE_GET,     ALL_ONES, '0);
    send_request(MODE_SET_GET, ALL_ONES, 64'h5555_aaaa_5555_aaaa);
    send_request(MODE_SET,     ALL_ONES, 64'haaaa_5555_aaaa_5555);
    send_request(MODE_POP,     '0,       '0);
    send_request(MODE_SET,     '0,       64'h0123_4567_89ab_cdef);
    key_pool.push_back('0);
    key_pool.push_back(ALL_ONES);

    snd_idle = 11;
    rcv_idle = 82;
    random_phase(630, 10);
    snd_idle = 82;
    rcv_idle = 11;
    random_phase(630, 25);
    snd_idle = 0;
    rcv_idle = 0;
    random_phase(630, 30);
    in_valid_i <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("tb_linear_probe_hash_map: PASS");
    end else begin
      $display("tb_linear_probe_hash_map: FAIL");
    end
    $finish;
  end

endmodule
